// ===== design/rbn_pkg.sv =====
`timescale 1ns / 1ps

package rbn_pkg;

    localparam int COORD_W  = 18;
    localparam int DIFF_W   = COORD_W + 1;      // side length or corner sum
    localparam int SIDE_W   = 36;               // resized side, 1/16 pixel
    localparam int DIV_W    = 34;               // divider dividend / quotient
    localparam int DREM_W   = 17;               // divider partial remainder
    localparam int RAD_W    = 2 * DIFF_W;       // radicand w*w + h*h
    localparam int ROOT_W   = DIFF_W;           // integer root
    localparam int SREM_W   = ROOT_W + 3;       // root partial remainder
    localparam int ITER_N   = DIV_W;            // one quotient bit per stage
    localparam int CORNER_W = SIDE_W + 1;

    localparam logic [3:0] MODE_WIDTH_LEN  = 4'd0;
    localparam logic [3:0] MODE_RATIO_A    = 4'd1;
    localparam logic [3:0] MODE_RATIO_B    = 4'd2;
    localparam logic [3:0] MODE_RATIO_C    = 4'd3;
    localparam logic [3:0] MODE_HEIGHT_LEN = 4'd4;
    localparam logic [3:0] MODE_LSIDE_LEN  = 4'd5;
    localparam logic [3:0] MODE_LSIDE_SQ   = 4'd6;
    localparam logic [3:0] MODE_DIAG_SQ    = 4'd7;
    localparam logic [3:0] MODE_WIDTH_SQ   = 4'd8;
    localparam logic [3:0] MODE_HEIGHT_SQ  = 4'd9;
    localparam logic [3:0] MODE_NONE       = 4'd10;

    localparam logic [2:0] CFG_NORM_MODE   = 3'd0;
    localparam logic [2:0] CFG_FILTER_MODE = 3'd1;
    localparam logic [2:0] CFG_SCALE       = 3'd2;
    localparam logic [2:0] CFG_AR          = 3'd3;
    localparam logic [2:0] CFG_FRAME_W     = 3'd4;
    localparam logic [2:0] CFG_FRAME_H     = 3'd5;

    localparam logic signed [CORNER_W-1:0] COORD_MAX = CORNER_W'(131071);
    localparam logic signed [CORNER_W-1:0] COORD_MIN = -CORNER_W'(131072);

    typedef struct packed {
        logic [3:0]  norm_mode;
        logic        filter_mode;
        logic [15:0] scale_q8;
        logic [15:0] ar_q8;
        logic [13:0] frame_w;
        logic [13:0] frame_h;
    } cfg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic signed [COORD_W-1:0] right;
        logic signed [COORD_W-1:0] bottom;
    } box_t;

    typedef struct packed {
        box_t                     box;
        logic                     passthru;
        logic                     bad;
        logic signed [DIFF_W-1:0] cx;
        logic signed [DIFF_W-1:0] cy;
        logic signed [SIDE_W-1:0] wn;
        logic signed [SIDE_W-1:0] hn;
        logic                     use_div;
        logic                     use_root;
        logic                     div_neg;
        logic [DIV_W-1:0]         div_num;
        logic [DREM_W-1:0]        div_rem;
        logic [RAD_W-1:0]         sq_rad;
        logic [SREM_W-1:0]        sq_rem;
        logic [ROOT_W-1:0]        sq_root;
    } work_t;

endpackage

// ===== design/roi_box_normalizer_core.sv =====
`timescale 1ns / 1ps

// Box resize, filter and clip engine.
// Input channel: in_valid / in_stall with the four corners box_left, box_top,
// box_right and box_bottom in signed 1/16 pixel. Output channel: out_valid /
// out_stall with out_left, out_top, out_right, out_bottom and rejected.
// Every box gives exactly one result beat, in order.
// There are 40 register stages: three front stages (input register, sides
// and products, mode select), 34 stages of the shared divider and root
// pipeline (one quotient bit a stage, sets the depth), two back stages and the
// output register. Throughput is one box per cycle unless the output stalls.
// A stalled output freezes the whole pipeline; in_stall then rises in the
// same cycle, so nothing is dropped and the output beat holds. Configuration is
// written through cfg_wr_en / cfg_index / cfg_data; the user must do so only
// while no box is in flight, which the block does not enforce. Reset clears
// every valid bit and loads the register defaults: mode none, filter off,
// scale and aspect 1.0, image 1920 x 1080.
module roi_box_normalizer_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [2:0]                         cfg_index,
    input  logic [15:0]                        cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [rbn_pkg::COORD_W-1:0] box_left,
    input  logic signed [rbn_pkg::COORD_W-1:0] box_top,
    input  logic signed [rbn_pkg::COORD_W-1:0] box_right,
    input  logic signed [rbn_pkg::COORD_W-1:0] box_bottom,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [rbn_pkg::COORD_W-1:0] out_left,
    output logic signed [rbn_pkg::COORD_W-1:0] out_top,
    output logic signed [rbn_pkg::COORD_W-1:0] out_right,
    output logic signed [rbn_pkg::COORD_W-1:0] out_bottom,
    output logic                               rejected
);

    rbn_pkg::cfg_t  cfg_reg;
    rbn_pkg::box_t  in_box;
    rbn_pkg::work_t front_work, iter_work;
    logic           front_valid, iter_valid;
    logic           adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.norm_mode   <= rbn_pkg::MODE_NONE;
            cfg_reg.filter_mode <= 1'b0;
            cfg_reg.scale_q8    <= 16'd256;
            cfg_reg.ar_q8       <= 16'd256;
            cfg_reg.frame_w     <= 14'd1920;
            cfg_reg.frame_h     <= 14'd1080;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                rbn_pkg::CFG_NORM_MODE:   cfg_reg.norm_mode   <= cfg_data[3:0];
                rbn_pkg::CFG_FILTER_MODE: cfg_reg.filter_mode <= cfg_data[0];
                rbn_pkg::CFG_SCALE:       cfg_reg.scale_q8    <= cfg_data;
                rbn_pkg::CFG_AR:          cfg_reg.ar_q8       <= cfg_data;
                rbn_pkg::CFG_FRAME_W:     cfg_reg.frame_w     <= cfg_data[13:0];
                rbn_pkg::CFG_FRAME_H:     cfg_reg.frame_h     <= cfg_data[13:0];
                default:                  cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // hold every stage while a result beat waits
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    assign in_box.left   = box_left;
    assign in_box.top    = box_top;
    assign in_box.right  = box_right;
    assign in_box.bottom = box_bottom;

    rbn_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_box     (in_box),
        .work_valid (front_valid),
        .work       (front_work)
    );

    rbn_iter u_iter (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (adv),
        .ar_q8          (cfg_reg.ar_q8),
        .work_in_valid  (front_valid),
        .work_in        (front_work),
        .work_out_valid (iter_valid),
        .work_out       (iter_work)
    );

    rbn_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .cfg        (cfg_reg),
        .work_valid (iter_valid),
        .work       (iter_work),
        .out_valid  (out_valid),
        .out_left   (out_left),
        .out_top    (out_top),
        .out_right  (out_right),
        .out_bottom (out_bottom),
        .rejected   (rejected)
    );

endmodule

// ===== design/rbn_front.sv =====
`timescale 1ns / 1ps

module rbn_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  rbn_pkg::cfg_t  cfg,
    input  logic           in_valid,
    input  rbn_pkg::box_t  in_box,
    output logic           work_valid,
    output rbn_pkg::work_t work
);

    localparam int DW = rbn_pkg::DIFF_W;
    localparam int SW = rbn_pkg::SIDE_W;

    // stage A: input register
    logic          a_valid_reg;
    rbn_pkg::box_t a_box_reg;

    // stage B: sides, sums and products
    logic                  b_valid_reg;
    rbn_pkg::box_t         b_box_reg;
    logic signed [DW-1:0]  b_w_reg, b_h_reg, b_cx_reg, b_cy_reg;
    logic signed [35:0]    b_wsp_reg, b_hsp_reg;
    logic signed [37:0]    b_ww_reg, b_hh_reg;

    logic signed [DW-1:0]  w_next, h_next, cx_next, cy_next;
    logic signed [35:0]    wsp_next, hsp_next;
    logic signed [37:0]    ww_next, hh_next;

    // stage C: mode selection
    logic                  c_valid_reg;
    rbn_pkg::work_t        c_work_reg;
    rbn_pkg::work_t        c_work_next;

    logic signed [SW-1:0]  ws, hs, w_ext, h_ext, hn_len, wn_len, ws_abs;
    logic signed [44:0]    hsa;
    logic signed [44:0]    hsa_sh;
    logic [15:0]           a_eff;
    logic                  w_gt_h;

    always_comb
    begin
        w_next   = $signed({a_box_reg.right[17], a_box_reg.right})
                 - $signed({a_box_reg.left[17], a_box_reg.left});
        h_next   = $signed({a_box_reg.bottom[17], a_box_reg.bottom})
                 - $signed({a_box_reg.top[17], a_box_reg.top});
        cx_next  = $signed({a_box_reg.right[17], a_box_reg.right})
                 + $signed({a_box_reg.left[17], a_box_reg.left});
        cy_next  = $signed({a_box_reg.bottom[17], a_box_reg.bottom})
                 + $signed({a_box_reg.top[17], a_box_reg.top});
        wsp_next = w_next * $signed({1'b0, cfg.scale_q8});
        hsp_next = h_next * $signed({1'b0, cfg.scale_q8});
        ww_next  = w_next * w_next;
        hh_next  = h_next * h_next;
    end

    always_comb
    begin
        ws     = b_wsp_reg >>> 8;
        hs     = b_hsp_reg >>> 8;
        w_ext  = SW'(b_w_reg);
        h_ext  = SW'(b_h_reg);
        w_gt_h = b_w_reg > b_h_reg;
        a_eff  = (cfg.ar_q8 == 16'd0) ? 16'd1 : cfg.ar_q8;
        hsa    = $signed(hs[27:0]) * $signed({1'b0, a_eff});
        hsa_sh = hsa >>> 8;
        hn_len = h_ext + ws - w_ext;
        wn_len = w_ext + hs - h_ext;
        ws_abs = ws[SW-1] ? -ws : ws;

        c_work_next          = '0;
        c_work_next.box      = b_box_reg;
        c_work_next.cx       = b_cx_reg;
        c_work_next.cy       = b_cy_reg;
        c_work_next.wn       = w_ext;
        c_work_next.hn       = h_ext;
        c_work_next.sq_rad   = rbn_pkg::RAD_W'(b_ww_reg) + rbn_pkg::RAD_W'(b_hh_reg);
        c_work_next.div_num  = {ws_abs[25:0], 8'd0};
        c_work_next.div_neg  = ws[SW-1];

        case (cfg.norm_mode)
            rbn_pkg::MODE_WIDTH_LEN:
            begin
                c_work_next.wn  = ws;
                c_work_next.hn  = hn_len;
                c_work_next.bad = hn_len[SW-1] || (hn_len == '0);
            end
            rbn_pkg::MODE_RATIO_A, rbn_pkg::MODE_RATIO_B, rbn_pkg::MODE_RATIO_C:
            begin
                c_work_next.wn = ws;
                c_work_next.hn = hs;
            end
            rbn_pkg::MODE_HEIGHT_LEN:
            begin
                c_work_next.hn  = hs;
                c_work_next.wn  = wn_len;
                c_work_next.bad = wn_len[SW-1] || (wn_len == '0);
            end
            rbn_pkg::MODE_LSIDE_LEN:
            begin
                if (w_gt_h)
                begin
                    c_work_next.wn  = ws;
                    c_work_next.hn  = hn_len;
                    c_work_next.bad = hn_len[SW-1] || (hn_len == '0);
                end
                else
                begin
                    c_work_next.hn  = hs;
                    c_work_next.wn  = wn_len;
                    c_work_next.bad = wn_len[SW-1] || (wn_len == '0);
                end
            end
            rbn_pkg::MODE_LSIDE_SQ:
            begin
                if (w_gt_h)
                begin
                    c_work_next.wn      = ws;
                    c_work_next.use_div = 1'b1;
                end
                else
                begin
                    c_work_next.hn = hs;
                    c_work_next.wn = hsa_sh[SW-1:0];
                end
            end
            rbn_pkg::MODE_DIAG_SQ:
            begin
                c_work_next.use_root = 1'b1;
            end
            rbn_pkg::MODE_WIDTH_SQ:
            begin
                c_work_next.wn = ws;
                c_work_next.hn = ws;
            end
            rbn_pkg::MODE_HEIGHT_SQ:
            begin
                c_work_next.wn = hs;
                c_work_next.hn = hs;
            end
            rbn_pkg::MODE_NONE:
            begin
                c_work_next.wn = w_ext;
            end
            default:
            begin
                c_work_next.passthru = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_box_reg  <= in_box;
            b_box_reg  <= a_box_reg;
            b_w_reg    <= w_next;
            b_h_reg    <= h_next;
            b_cx_reg   <= cx_next;
            b_cy_reg   <= cy_next;
            b_wsp_reg  <= wsp_next;
            b_hsp_reg  <= hsp_next;
            b_ww_reg   <= ww_next;
            b_hh_reg   <= hh_next;
            c_work_reg <= c_work_next;
        end
    end

    assign work_valid = c_valid_reg;
    assign work       = c_work_reg;

endmodule

// ===== design/rbn_iter.sv =====
`timescale 1ns / 1ps

module rbn_iter (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic [15:0]    ar_q8,
    input  logic           work_in_valid,
    input  rbn_pkg::work_t work_in,
    output logic           work_out_valid,
    output rbn_pkg::work_t work_out
);

    localparam int N  = rbn_pkg::ITER_N;
    localparam int DW = rbn_pkg::DIV_W;
    localparam int RW = rbn_pkg::ROOT_W;
    localparam int SR = rbn_pkg::SREM_W;

    logic [15:0]    a_eff;
    logic           valid_reg [N];
    rbn_pkg::work_t stage_reg [N];

    assign a_eff = (ar_q8 == 16'd0) ? 16'd1 : ar_q8;

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_stage
            rbn_pkg::work_t            prev;
            rbn_pkg::work_t            stage_next;
            logic [rbn_pkg::DREM_W-1:0] rem2;
            logic [SR-1:0]             sr, trial;

            if (k == 0)
            begin : g_first
                assign prev = work_in;
            end
            else
            begin : g_rest
                assign prev = stage_reg[k-1];
            end

            always_comb
            begin
                stage_next = prev;
                // restoring division: one quotient bit per stage
                rem2 = {prev.div_rem[15:0], prev.div_num[DW-1]};
                if (rem2 >= {1'b0, a_eff})
                begin
                    stage_next.div_rem = rem2 - {1'b0, a_eff};
                    stage_next.div_num = {prev.div_num[DW-2:0], 1'b1};
                end
                else
                begin
                    stage_next.div_rem = rem2;
                    stage_next.div_num = {prev.div_num[DW-2:0], 1'b0};
                end
                // digit-by-digit root over the first stages, then hold
                sr    = {prev.sq_rem[SR-3:0], prev.sq_rad[rbn_pkg::RAD_W-1 -: 2]};
                trial = {1'b0, prev.sq_root, 2'b01};
                if (k < RW)
                begin
                    stage_next.sq_rad = {prev.sq_rad[rbn_pkg::RAD_W-3:0], 2'b00};
                    if (sr >= trial)
                    begin
                        stage_next.sq_rem  = sr - trial;
                        stage_next.sq_root = {prev.sq_root[RW-2:0], 1'b1};
                    end
                    else
                    begin
                        stage_next.sq_rem  = sr;
                        stage_next.sq_root = {prev.sq_root[RW-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (adv)
                begin
                    valid_reg[k] <= (k == 0) ? work_in_valid : valid_reg[(k == 0) ? 0 : k-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    stage_reg[k] <= stage_next;
                end
            end
        end
    endgenerate

    assign work_out_valid = valid_reg[N-1];
    assign work_out       = stage_reg[N-1];

endmodule

// ===== design/rbn_back.sv =====
`timescale 1ns / 1ps

module rbn_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               adv,
    input  rbn_pkg::cfg_t                      cfg,
    input  logic                               work_valid,
    input  rbn_pkg::work_t                     work,
    output logic                               out_valid,
    output logic signed [rbn_pkg::COORD_W-1:0] out_left,
    output logic signed [rbn_pkg::COORD_W-1:0] out_top,
    output logic signed [rbn_pkg::COORD_W-1:0] out_right,
    output logic signed [rbn_pkg::COORD_W-1:0] out_bottom,
    output logic                               rejected
);

    localparam int SW = rbn_pkg::SIDE_W;
    localparam int CW = rbn_pkg::CORNER_W;
    localparam int DW_Q = rbn_pkg::DIV_W + 1;

    // stage D: final sides
    logic                  d_valid_reg;
    rbn_pkg::box_t         d_box_reg;
    logic                  d_pass_reg, d_bad_reg;
    logic signed [rbn_pkg::DIFF_W-1:0] d_cx_reg, d_cy_reg;
    logic signed [SW-1:0]  d_wn_reg, d_hn_reg;
    logic signed [SW-1:0]  wn_next, hn_next, quot;
    logic [DW_Q-1:0]       qmag;
    logic [34:0]           root_prod;

    // stage E: corners and filter
    logic                  e_valid_reg;
    rbn_pkg::box_t         e_box_reg;
    logic                  e_pass_reg, e_rej_reg;
    logic signed [CW-1:0]  e_l_reg, e_t_reg, e_r_reg, e_b_reg;
    logic signed [CW-1:0]  nl, nt, nr, nb, maxx, maxy;
    logic                  rej_next;

    // output register
    logic                  o_valid_reg, o_rej_reg;
    logic signed [rbn_pkg::COORD_W-1:0] o_l_reg, o_t_reg, o_r_reg, o_b_reg;
    logic signed [rbn_pkg::COORD_W-1:0] o_l_next, o_t_next, o_r_next, o_b_next;
    logic                  o_rej_next;
    logic signed [CW-1:0]  cl, ct, cr, cb;

    function automatic logic signed [rbn_pkg::COORD_W-1:0] sat18(
        input logic signed [rbn_pkg::CORNER_W-1:0] v);
        logic signed [rbn_pkg::CORNER_W-1:0] r;
        begin
            if (v > rbn_pkg::COORD_MAX)
                r = rbn_pkg::COORD_MAX;
            else if (v < rbn_pkg::COORD_MIN)
                r = rbn_pkg::COORD_MIN;
            else
                r = v;
            return r[rbn_pkg::COORD_W-1:0];
        end
    endfunction

    always_comb
    begin
        // floor division: round the magnitude up when the dividend is negative
        qmag = {1'b0, work.div_num}
             + DW_Q'(work.div_neg && (work.div_rem != '0));
        quot = work.div_neg ? -SW'(qmag) : SW'(qmag);
        root_prod = work.sq_root * cfg.scale_q8;
        wn_next = work.wn;
        hn_next = work.hn;
        priority if (work.use_root)
        begin
            wn_next = SW'(root_prod[34:8]);
            hn_next = SW'(root_prod[34:8]);
        end
        else if (work.use_div)
        begin
            hn_next = quot;
        end
    end

    always_comb
    begin
        nl   = (CW'(d_cx_reg) - CW'(d_wn_reg)) >>> 1;
        nr   = (CW'(d_cx_reg) + CW'(d_wn_reg)) >>> 1;
        nt   = (CW'(d_cy_reg) - CW'(d_hn_reg)) >>> 1;
        nb   = (CW'(d_cy_reg) + CW'(d_hn_reg)) >>> 1;
        maxx = CW'({cfg.frame_w, 4'd0});
        maxy = CW'({cfg.frame_h, 4'd0});
        rej_next = d_bad_reg
                || (cfg.filter_mode && (nl[CW-1] || nt[CW-1] || (nr > maxx) || (nb > maxy)));
    end

    always_comb
    begin
        maxx_clip:
        begin
            cl = e_l_reg[CW-1] ? '0 : e_l_reg;
            ct = e_t_reg[CW-1] ? '0 : e_t_reg;
            cr = (e_r_reg > maxx) ? maxx : e_r_reg;
            cb = (e_b_reg > maxy) ? maxy : e_b_reg;
        end
        if (e_pass_reg || e_rej_reg)
        begin
            o_l_next   = e_box_reg.left;
            o_t_next   = e_box_reg.top;
            o_r_next   = e_box_reg.right;
            o_b_next   = e_box_reg.bottom;
            o_rej_next = e_rej_reg && !e_pass_reg;
        end
        else
        begin
            o_l_next   = sat18(cl);
            o_t_next   = sat18(ct);
            o_r_next   = sat18(cr);
            o_b_next   = sat18(cb);
            o_rej_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            d_valid_reg <= work_valid;
            e_valid_reg <= d_valid_reg;
            o_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_box_reg  <= work.box;
            d_pass_reg <= work.passthru;
            d_bad_reg  <= work.bad;
            d_cx_reg   <= work.cx;
            d_cy_reg   <= work.cy;
            d_wn_reg   <= wn_next;
            d_hn_reg   <= hn_next;
            e_box_reg  <= d_box_reg;
            e_pass_reg <= d_pass_reg;
            e_rej_reg  <= rej_next;
            e_l_reg    <= nl;
            e_t_reg    <= nt;
            e_r_reg    <= nr;
            e_b_reg    <= nb;
            o_l_reg    <= o_l_next;
            o_t_reg    <= o_t_next;
            o_r_reg    <= o_r_next;
            o_b_reg    <= o_b_next;
            o_rej_reg  <= o_rej_next;
        end
    end

    assign out_valid  = o_valid_reg;
    assign out_left   = o_l_reg;
    assign out_top    = o_t_reg;
    assign out_right  = o_r_reg;
    assign out_bottom = o_b_reg;
    assign rejected   = o_rej_reg;

endmodule

// ===== bench/tb_roi_box_normalizer_core.sv =====
`timescale 1ns / 1ps

module tb_roi_box_normalizer_core;

    typedef struct {
        logic signed [17:0] l;
        logic signed [17:0] t;
        logic signed [17:0] r;
        logic signed [17:0] b;
        logic               rej;
    } norm_res_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic signed [rbn_pkg::COORD_W-1:0] box_left, box_top, box_right, box_bottom;
    logic        out_valid;
    logic        out_stall;
    logic signed [rbn_pkg::COORD_W-1:0] out_left, out_top, out_right, out_bottom;
    logic        rejected;

    rbn_pkg::box_t pending_boxes[$];
    norm_res_t     expected_boxes[$];
    int            mismatches;
    bit            idling_on;

    // shadow of the register file
    logic [3:0]  sh_mode;
    logic        sh_filter;
    logic [15:0] sh_scale;
    logic [15:0] sh_aspect;
    logic [13:0] sh_width;
    logic [13:0] sh_height;

    roi_box_normalizer_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .box_left   (box_left),
        .box_top    (box_top),
        .box_right  (box_right),
        .box_bottom (box_bottom),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_left   (out_left),
        .out_top    (out_top),
        .out_right  (out_right),
        .out_bottom (out_bottom),
        .rejected   (rejected)
    );

    function automatic longint floor_div(longint n, longint d);
        longint q;
        begin
            q = n / d;
            if ((n % d) != 0 && n < 0)
                q = q - 1;
            return q;
        end
    endfunction

    function automatic longint int_root(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        begin
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > v)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (v >= res + bitv)
                begin
                    v   = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
            return longint'(res);
        end
    endfunction

    function automatic longint clamp18(longint v);
        begin
            if (v > 131071)
                return 131071;
            if (v < -131072)
                return -131072;
            return v;
        end
    endfunction

    function automatic norm_res_t resize_box(rbn_pkg::box_t bx);
        norm_res_t res;
        longint l, t, r, b, w, h, wn, hn, a, s, nl, nt, nr, nb, mx, my;
        bit bad;
        begin
            l = bx.left; t = bx.top; r = bx.right; b = bx.bottom;
            w = r - l; h = b - t; wn = w; hn = h;
            a = (sh_aspect == 0) ? 1 : longint'(sh_aspect);
            s = longint'(sh_scale);
            bad = 0;
            res.l = bx.left; res.t = bx.top; res.r = bx.right; res.b = bx.bottom;
            res.rej = 0;
            case (sh_mode)
                rbn_pkg::MODE_WIDTH_LEN:
                begin
                    wn = floor_div(w * s, 256); hn = h + wn - w; bad = hn <= 0;
                end
                rbn_pkg::MODE_RATIO_A, rbn_pkg::MODE_RATIO_B, rbn_pkg::MODE_RATIO_C:
                begin
                    wn = floor_div(w * s, 256); hn = floor_div(h * s, 256);
                end
                rbn_pkg::MODE_HEIGHT_LEN:
                begin
                    hn = floor_div(h * s, 256); wn = w + hn - h; bad = wn <= 0;
                end
                rbn_pkg::MODE_LSIDE_LEN:
                    if (w > h)
                    begin
                        wn = floor_div(w * s, 256); hn = h + wn - w; bad = hn <= 0;
                    end
                    else
                    begin
                        hn = floor_div(h * s, 256); wn = w + hn - h; bad = wn <= 0;
                    end
                rbn_pkg::MODE_LSIDE_SQ:
                    if (w > h)
                    begin
                        wn = floor_div(w * s, 256); hn = floor_div(wn * 256, a);
                    end
                    else
                    begin
                        hn = floor_div(h * s, 256); wn = floor_div(hn * a, 256);
                    end
                rbn_pkg::MODE_DIAG_SQ:
                begin
                    wn = floor_div(int_root(w * w + h * h) * s, 256); hn = wn;
                end
                rbn_pkg::MODE_WIDTH_SQ:
                begin
                    wn = floor_div(w * s, 256); hn = wn;
                end
                rbn_pkg::MODE_HEIGHT_SQ:
                begin
                    hn = floor_div(h * s, 256); wn = hn;
                end
                rbn_pkg::MODE_NONE: ;
                default:
                    return res;
            endcase
            if (bad)
            begin
                res.rej = 1;
                return res;
            end
            nl = floor_div(l + r - wn, 2);
            nr = floor_div(l + r + wn, 2);
            nt = floor_div(t + b - hn, 2);
            nb = floor_div(t + b + hn, 2);
            mx = longint'(sh_width) * 16;
            my = longint'(sh_height) * 16;
            if (sh_filter && (nl < 0 || nt < 0 || nr > mx || nb > my))
            begin
                res.rej = 1;
                return res;
            end
            if (nl < 0) nl = 0;
            if (nt < 0) nt = 0;
            if (nr > mx) nr = mx;
            if (nb > my) nb = my;
            res.l = 18'(clamp18(nl)); res.t = 18'(clamp18(nt));
            res.r = 18'(clamp18(nr)); res.b = 18'(clamp18(nb));
            return res;
        end
    endfunction

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 0;
            box_left   <= '0;
            box_top    <= '0;
            box_right  <= '0;
            box_bottom <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_boxes.push_back(resize_box('{box_left, box_top, box_right,
                                                       box_bottom}));
            if (!in_valid || !in_stall)
            begin
                if (pending_boxes.size() != 0 &&
                    (!idling_on || $urandom_range(99) >= 31))
                begin
                    rbn_pkg::box_t nb;
                    nb = pending_boxes.pop_front();
                    box_left   <= nb.left;
                    box_top    <= nb.top;
                    box_right  <= nb.right;
                    box_bottom <= nb.bottom;
                    in_valid   <= 1;
                end
                else
                    in_valid <= 0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 0;
        else
        begin
            out_stall <= idling_on && ($urandom_range(99) < 31);
            if (out_valid && !out_stall)
            begin
                if (expected_boxes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat %0d %0d %0d %0d rej %0b",
                                 out_left, out_top, out_right, out_bottom, rejected);
                end
                else
                begin
                    norm_res_t e;
                    e = expected_boxes.pop_front();
                    if (e.l !== out_left || e.t !== out_top || e.r !== out_right ||
                        e.b !== out_bottom || e.rej !== rejected)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp %0d %0d %0d %0d rej %0b, got %0d %0d %0d %0d rej %0b",
                                     e.l, e.t, e.r, e.b, e.rej,
                                     out_left, out_top, out_right, out_bottom, rejected);
                    end
                end
            end
        end
    end

    task automatic write_regs(logic [3:0] mode, logic filt, logic [15:0] scl,
                              logic [15:0] asp, logic [13:0] iw, logic [13:0] ih);
        logic [15:0] vals[6];
        begin
            vals = '{16'(mode), 16'(filt), scl, asp, 16'(iw), 16'(ih)};
            for (int i = 0; i < 6; i++)
            begin
                @(posedge clk);
                cfg_wr_en <= 1;
                cfg_index <= 3'(i);
                cfg_data  <= vals[i];
            end
            @(posedge clk);
            cfg_wr_en <= 0;
            sh_mode = mode; sh_filter = filt; sh_scale = scl;
            sh_aspect = asp; sh_width = iw; sh_height = ih;
        end
    endtask

    task automatic drain;
        begin
            while (pending_boxes.size() != 0 || expected_boxes.size() != 0 || in_valid)
                @(posedge clk);
            repeat (50) @(posedge clk);
        end
    endtask

    function automatic rbn_pkg::box_t random_box();
        rbn_pkg::box_t bx;
        int l, t, w, h;
        begin
            if ($urandom_range(99) < 20)
            begin
                bx.left = 18'($urandom); bx.top = 18'($urandom);
                bx.right = 18'($urandom); bx.bottom = 18'($urandom);
            end
            else
            begin
                l = $urandom_range(36000) - 4000;
                t = $urandom_range(22000) - 4000;
                w = $urandom_range(1, ($urandom_range(3) == 0) ? 60000 : 4000);
                h = $urandom_range(1, ($urandom_range(3) == 0) ? 60000 : 4000);
                bx.left = 18'(l); bx.top = 18'(t);
                bx.right = 18'(l + w); bx.bottom = 18'(t + h);
            end
            return bx;
        end
    endfunction

    function automatic logic [15:0] pick_scale();
        case ($urandom_range(5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'd256;
            default: return 16'($urandom_range(64, 1024));
        endcase
    endfunction

    function automatic logic [13:0] pick_size();
        case ($urandom_range(4))
            0: return 14'd1;
            1: return 14'd8192;
            2: return 14'd0;
            default: return 14'($urandom_range(1, 8192));
        endcase
    endfunction

    initial
    begin
        rst_n = 0; cfg_wr_en = 0; cfg_index = '0; cfg_data = '0; idling_on = 1;
        mismatches = 0;
        sh_mode = rbn_pkg::MODE_NONE; sh_filter = 0; sh_scale = 256; sh_aspect = 256;
        sh_width = 1920; sh_height = 1080;
        repeat (9) @(posedge clk);
        rst_n <= 1;

        // corner values, zero and inverted boxes under reset settings
        pending_boxes.push_back('{-18'sd131072, -18'sd131072, 18'sd131071, 18'sd131071});
        pending_boxes.push_back('{18'sd131071, 18'sd131071, -18'sd131072, -18'sd131072});
        pending_boxes.push_back('{18'sd0, 18'sd0, 18'sd0, 18'sd0});
        pending_boxes.push_back('{18'sd100, 18'sd100, 18'sd30000, 18'sd17000});
        pending_boxes.push_back('{-18'sd1, -18'sd1, 18'sd1, 18'sd1});
        drain();
        // every mode code 0 to 15 once on a wide and a tall box, filter on for odd codes
        for (int m = 0; m < 16; m++)
        begin
            write_regs(4'(m), m[0], (m == 7) ? 16'hFFFF : 16'd384,
                       (m == 6) ? 16'd0 : 16'd200, 14'd8192, 14'd1);
            pending_boxes.push_back('{18'sd1000, 18'sd1000, 18'sd3000, 18'sd1500});
            pending_boxes.push_back('{18'sd1000, 18'sd1000, 18'sd1400, 18'sd5000});
            drain();
        end

        for (int ph = 0; ph < 24; ph++)
        begin
            idling_on = (ph != 5);
            write_regs(4'(ph % 16), 1'($urandom_range(1)), pick_scale(),
                       (ph % 4 == 0) ? 16'hFFFF : 16'($urandom_range(0, 1024)),
                       pick_size(), pick_size());
            repeat (36) pending_boxes.push_back(random_box());
            drain();
        end

        if (mismatches == 0)
            $display("tb_roi_box_normalizer_core: clean");
        else
            $display("tb_roi_box_normalizer_core: errors");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("tb_roi_box_normalizer_core: errors");
        $finish;
    end

endmodule
